// File: hdl/sdn_pkg.sv
// ----------------------------------------------------------------------------
// sdn_pkg
// Shared widths, codes, types and helpers of the D8 flow direction block.
// ----------------------------------------------------------------------------
package sdn_pkg;

    localparam int HEIGHT_W = 24;
    localparam int DROP_W   = 25;
    localparam int DIR_W    = 4;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int KEY_W    = 42;
    localparam int WIN_N    = 9;
    localparam int NEIGH_N  = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int GRID_COLS_W = 11;
    localparam int GRID_ROWS_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int RST_COLUMNS     = 1024;
    localparam int RST_ROWS        = 1024;
    localparam int MIN_GRID        = 3;

    localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;

    localparam logic signed [16:0] DIAG_WEIGHT = 17'sd46341;
    localparam int ORTHO_SHIFT = 16;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             interior;
        logic             border;
    } t_meta;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [DROP_W-1:0] drop;
        logic [DIR_W-1:0]         dir;
    } t_cand;

    function automatic int clamp_last(input int v, input int hi);
        int c;
        c = v;
        if (c < MIN_GRID) begin
            c = MIN_GRID;
        end else if (c > hi) begin
            c = hi;
        end
        return c - 1;
    endfunction

    function automatic int win_pos(input int k);
        return (k < 4) ? k : k + 1;
    endfunction

endpackage

// File: hdl/sdn_line_buf.sv
// ----------------------------------------------------------------------------
// sdn_line_buf
// Two line memories holding the two rows above the incoming one.
// ----------------------------------------------------------------------------
// Each column is read when its cell arrives and written back later, when that
// cell enters the window. A column is revisited only a full row later, so
// reads and writes never touch the same entry in overlapping cycles.
module sdn_line_buf
    import sdn_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [HEIGHT_W-1:0] o_up,
    output logic [HEIGHT_W-1:0] o_mid,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [HEIGHT_W-1:0] i_wr_data
);

    logic [HEIGHT_W-1:0] mem_up  [DEPTH];
    logic [HEIGHT_W-1:0] mem_mid [DEPTH];
    logic [HEIGHT_W-1:0] r_up_q;
    logic [HEIGHT_W-1:0] r_mid_q;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q  <= mem_up[i_rd_addr];
            r_mid_q <= mem_mid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_up[i_wr_addr]  <= r_mid_q;
            mem_mid[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_up  = r_up_q;
    assign o_mid = r_mid_q;

endmodule

// File: hdl/sdn_select.sv
// ----------------------------------------------------------------------------
// sdn_select
// 3x3 window and steepest-descent neighbour selection pipeline.
// ----------------------------------------------------------------------------
module sdn_select
    import sdn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [HEIGHT_W-1:0] i_up,
    input  logic [HEIGHT_W-1:0] i_mid,
    input  logic [HEIGHT_W-1:0] i_new,
    input  t_meta               i_meta,
    input  logic                i_out_ok,
    output logic                o_free,
    output logic                o_pop,
    output t_meta               o_meta,
    output t_cand               o_cand
);

    logic [HEIGHT_W-1:0] r_win [WIN_N];

    logic  r_s2_v, r_s3_v, r_s4_v;
    t_meta r_s2_meta, r_s3_meta, r_s4_meta;
    t_cand r_s3_cand [NEIGH_N];
    t_cand r_s4_cand [2];
    t_cand n_s3_cand [NEIGH_N];
    t_cand n_s4_cand [2];
    logic  free3, free4;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        return ($signed(b.key) > $signed(a.key)) ? b : a;
    endfunction

    assign free4  = !r_s4_v || !(r_s4_meta.interior || r_s4_meta.border) || i_out_ok;
    assign free3  = !r_s3_v || free4;
    assign o_free = !r_s2_v || free3;
    assign o_pop  = r_s4_v && (r_s4_meta.interior || r_s4_meta.border) && i_out_ok;

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_up;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= i_mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= i_new;
        end
    end

    always_comb begin
        int p;
        logic signed [DROP_W-1:0] d;
        for (int k = 0; k < NEIGH_N; k++) begin
            p = win_pos(k);
            d = $signed({1'b0, r_win[4]}) - $signed({1'b0, r_win[p]});
            n_s3_cand[k].drop = d;
            n_s3_cand[k].dir  = DIR_W'(k + 1);
            if ((p % 2) == 0) begin
                n_s3_cand[k].key = d * DIAG_WEIGHT;
            end else begin
                n_s3_cand[k].key = {{(KEY_W - DROP_W - ORTHO_SHIFT){d[DROP_W-1]}},
                                    d, {ORTHO_SHIFT{1'b0}}};
            end
        end
    end

    always_comb begin
        n_s4_cand[0] = pick(pick(r_s3_cand[0], r_s3_cand[1]),
                            pick(r_s3_cand[2], r_s3_cand[3]));
        n_s4_cand[1] = pick(pick(r_s3_cand[4], r_s3_cand[5]),
                            pick(r_s3_cand[6], r_s3_cand[7]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (o_free) begin
                r_s2_v <= i_take;
            end
            if (free3) begin
                r_s3_v <= r_s2_v;
            end
            if (free4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s2_meta <= i_meta;
        end
        if (free3 && r_s2_v) begin
            r_s3_meta <= r_s2_meta;
            r_s3_cand <= n_s3_cand;
        end
        if (free4 && r_s3_v) begin
            r_s4_meta <= r_s3_meta;
            r_s4_cand <= n_s4_cand;
        end
    end

    assign o_meta = r_s4_meta;
    assign o_cand = pick(r_s4_cand[0], r_s4_cand[1]);

endmodule

// File: hdl/steepest_descent_neighbour_top.sv
// ----------------------------------------------------------------------------
// steepest_descent_neighbour_top
// D8 flow direction over a raster-streamed grid of surface heights.
// ----------------------------------------------------------------------------
// The block takes one height beat per clock unless the pipeline stalls, and
// reports, for every interior cell, the neighbour of steepest descent, and
// direction 0 for every border cell. An input beat gives zero, one or two
// result beats; a cell whose beat gives two results (the right-hand column
// from the third row on and the bottom row from the third column on) holds
// the output register for a second result beat, otherwise the rate is one
// cell per clock while the receiver is ready. A result passes through the
// line memory read, the window update, the slope products and the compare
// tree on its way to the output register. Writing either grid size restarts
// the frame at row 0, column 0.
module steepest_descent_neighbour_top
    import sdn_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // surface_height[23:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // direction[3:0], height_drop[28:4], cell_row[40:29], cell_column[50:41]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COL_CW = $clog2(MAX_COLUMNS);
    localparam int ROW_CW = $clog2(MAX_ROWS);
    localparam logic [COL_CW-1:0] LAST_COL_RST = COL_CW'(clamp_last(RST_COLUMNS, MAX_COLUMNS));
    localparam logic [ROW_CW-1:0] LAST_ROW_RST = ROW_CW'(clamp_last(RST_ROWS, MAX_ROWS));

    logic [COL_CW-1:0] r_col, r_last_col;
    logic [ROW_CW-1:0] r_row, r_last_row;

    logic                r_s1_v;
    logic [HEIGHT_W-1:0] r_s1_h;
    logic [COL_CW-1:0]   r_s1_addr;
    t_meta               r_s1_meta;

    logic                r_ov, r_oint, r_obord;
    t_meta               r_o_meta;
    t_cand               r_o_cand;

    logic                acc, free1, free2, take, pop, out_ok, last_done;
    logic [HEIGHT_W-1:0] up_q, mid_q;
    t_meta               n_meta, s4_meta;
    t_cand               s4_cand;
    logic [DIR_W-1:0]    beat_dir;
    logic [DROP_W-1:0]   beat_drop;
    logic [ROW_W-1:0]    beat_row;
    logic [COL_W-1:0]    beat_col;

    assign free1         = !r_s1_v || free2;
    assign s_axis_tready = free1;
    assign acc           = s_axis_tvalid && free1;
    assign take          = r_s1_v && free2;

    always_comb begin
        n_meta.row      = ROW_W'(r_row);
        n_meta.col      = COL_W'(r_col);
        n_meta.interior = (r_row >= ROW_CW'(2)) && (r_col >= COL_CW'(2));
        n_meta.border   = (r_row == '0) || (r_col == '0) ||
                          (r_col == r_last_col) || (r_row == r_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= LAST_COL_RST;
            r_last_row <= LAST_ROW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_COLUMNS: begin
                    r_last_col <= COL_CW'(clamp_last(int'(i_cfg_data[GRID_COLS_W-1:0]),
                                                     MAX_COLUMNS));
                end
                CFG_GRID_ROWS: begin
                    r_last_row <= ROW_CW'(clamp_last(int'(i_cfg_data[GRID_ROWS_W-1:0]),
                                                     MAX_ROWS));
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + ROW_CW'(1);
            end else begin
                r_col <= r_col + COL_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (free1) begin
            r_s1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_h    <= s_axis_tdata[HEIGHT_W-1:0];
            r_s1_addr <= r_col;
            r_s1_meta <= n_meta;
        end
    end

    sdn_line_buf #(
        .DEPTH (MAX_COLUMNS),
        .AW    (COL_CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_up      (up_q),
        .o_mid     (mid_q),
        .i_wr_en   (take),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_h)
    );

    sdn_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_up     (up_q),
        .i_mid    (mid_q),
        .i_new    (r_s1_h),
        .i_meta   (r_s1_meta),
        .i_out_ok (out_ok),
        .o_free   (free2),
        .o_pop    (pop),
        .o_meta   (s4_meta),
        .o_cand   (s4_cand)
    );

    always_comb begin
        if (r_oint) begin
            beat_dir  = r_o_cand.dir;
            beat_drop = r_o_cand.drop;
            beat_row  = r_o_meta.row - ROW_W'(1);
            beat_col  = r_o_meta.col - COL_W'(1);
        end else begin
            beat_dir  = DIR_NONE;
            beat_drop = '0;
            beat_row  = r_o_meta.row;
            beat_col  = r_o_meta.col;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = !(r_oint && r_obord);
    assign m_axis_tdata  = {{(OUT_TDATA_W - DIR_W - DROP_W - ROW_W - COL_W){1'b0}},
                            beat_col, beat_row, beat_drop, beat_dir};
    assign last_done     = r_ov && m_axis_tready && m_axis_tlast;
    assign out_ok        = !r_ov || last_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_oint  <= 1'b0;
            r_obord <= 1'b0;
        end else if (pop) begin
            r_ov    <= 1'b1;
            r_oint  <= s4_meta.interior;
            r_obord <= s4_meta.border;
        end else if (last_done) begin
            r_ov <= 1'b0;
        end else if (r_ov && m_axis_tready) begin
            r_oint <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_meta <= s4_meta;
            r_o_cand <= s4_cand;
        end
    end

`ifndef SYNTHESIS
    a_out_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_oint || r_obord))
        else $error("output register holds an item with no result");

    a_interior_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oint) |-> (r_o_cand.dir != DIR_NONE))
        else $error("interior result without a neighbour direction");

    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last_done && !pop) |=> !r_ov)
        else $error("output stays valid after its last beat");

    a_counter_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_last_col) && (r_row <= r_last_row))
        else $error("raster position beyond the grid");
`endif

endmodule

// File: test/sdn_flow_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdn_flow_checker
// Watches the height, result and grid-size ports of the D8 flow direction
// block. It keeps its own line stores, 3x3 window and raster position, and
// works out the expected flow results for every accepted height beat. Each
// result beat is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module sdn_flow_checker
    import sdn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // surface_height[23:0]
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // direction[3:0], height_drop[28:4], cell_row[40:29], cell_column[50:41]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int unsigned            o_pending,
    output int unsigned            o_mismatches
);

    localparam int DIR_LSB  = 0;
    localparam int DROP_LSB = DIR_LSB + DIR_W;
    localparam int ROW_LSB  = DROP_LSB + DROP_W;
    localparam int COL_LSB  = ROW_LSB + ROW_W;
    localparam int CENTRE   = 4;
    localparam longint DIAG_GAIN  = 46341;
    localparam longint ORTHO_GAIN = 65536;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [DIR_W-1:0]         dir;
        logic signed [DROP_W-1:0] drop;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     ends_run;
    } t_flow_cell;

    logic [HEIGHT_W-1:0]    upper_line [DEF_MAX_COLUMNS];
    logic [HEIGHT_W-1:0]    middle_line [DEF_MAX_COLUMNS];
    logic [HEIGHT_W-1:0]    win [WIN_N];
    int unsigned            col_now;
    int unsigned            row_now;
    logic [GRID_COLS_W-1:0] cols_reg;
    logic [GRID_ROWS_W-1:0] rows_reg;
    t_flow_cell             flow_expected [$];
    int unsigned            mismatch_count = 0;

    function automatic int unsigned grid_span(input int unsigned v, input int unsigned hi);
        return (v < MIN_GRID) ? MIN_GRID : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned r,
                                   input int unsigned c, input longint want,
                                   input longint got);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t: %s wrong at cell (%0d,%0d): expected %0d, got %0d",
                     $time, what, r, c, want, got);
        end
        mismatch_count++;
    endtask

    // Shifts one height into the window and line stores and queues the flow
    // results that this raster position produces.
    task automatic advance_height_grid(input logic [HEIGHT_W-1:0] h);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned dir;
        int          k;
        int          drop;
        int          best_drop;
        longint      key;
        longint      best_key;
        logic [DIR_W-1:0] best_dir;
        logic        on_border;
        t_flow_cell  exp_beat;
        ncols = grid_span(cols_reg, DEF_MAX_COLUMNS);
        nrows = grid_span(rows_reg, DEF_MAX_ROWS);
        for (k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = upper_line[col_now];
        win[5] = middle_line[col_now];
        win[8] = h;
        upper_line[col_now]  = middle_line[col_now];
        middle_line[col_now] = h;
        on_border = (row_now == 0) || (col_now == 0) || (col_now >= ncols - 1)
                    || (row_now >= nrows - 1);
        if (row_now >= 2 && col_now >= 2) begin
            dir       = 0;
            best_key  = 0;
            best_drop = 0;
            best_dir  = DIR_NONE;
            for (k = 0; k < WIN_N; k++) begin
                if (k != CENTRE) begin
                    dir++;
                    drop = int'(win[CENTRE]) - int'(win[k]);
                    key  = longint'(drop) * (((k % 2) == 0) ? DIAG_GAIN : ORTHO_GAIN);
                    if (dir == 1 || key > best_key) begin
                        best_key  = key;
                        best_drop = drop;
                        best_dir  = DIR_W'(dir);
                    end
                end
            end
            exp_beat.dir      = best_dir;
            exp_beat.drop     = best_drop[DROP_W-1:0];
            exp_beat.row      = ROW_W'(row_now - 1);
            exp_beat.col      = COL_W'(col_now - 1);
            exp_beat.ends_run = !on_border;
            flow_expected.push_back(exp_beat);
        end
        if (on_border) begin
            exp_beat.dir      = DIR_NONE;
            exp_beat.drop     = '0;
            exp_beat.row      = ROW_W'(row_now);
            exp_beat.col      = COL_W'(col_now);
            exp_beat.ends_run = 1'b1;
            flow_expected.push_back(exp_beat);
        end
        col_now++;
        if (col_now >= ncols) begin
            col_now = 0;
            row_now++;
            if (row_now >= nrows) begin
                row_now = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_flow_cell want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEF_MAX_COLUMNS; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (int k = 0; k < WIN_N; k++) begin
                win[k] = '0;
            end
            col_now  = 0;
            row_now  = 0;
            cols_reg = GRID_COLS_W'(RST_COLUMNS);
            rows_reg = GRID_ROWS_W'(RST_ROWS);
            flow_expected.delete();
        end else begin
            if ($isunknown(i_m_tvalid)) begin
                report_mismatch("result valid", 0, 0, 0, 0);
            end else if (i_m_tvalid && i_m_tready) begin
                if (flow_expected.size() == 0) begin
                    report_mismatch("unexpected result beat",
                                    i_m_tdata[ROW_LSB +: ROW_W],
                                    i_m_tdata[COL_LSB +: COL_W], 0, 1);
                end else begin
                    want = flow_expected.pop_front();
                    if (i_m_tdata[DIR_LSB +: DIR_W] !== want.dir) begin
                        report_mismatch("direction", want.row, want.col, want.dir,
                                        i_m_tdata[DIR_LSB +: DIR_W]);
                    end
                    if (i_m_tdata[DROP_LSB +: DROP_W] !== want.drop) begin
                        report_mismatch("height_drop", want.row, want.col,
                                        $signed(want.drop),
                                        $signed(i_m_tdata[DROP_LSB +: DROP_W]));
                    end
                    if (i_m_tdata[ROW_LSB +: ROW_W] !== want.row) begin
                        report_mismatch("cell_row", want.row, want.col, want.row,
                                        i_m_tdata[ROW_LSB +: ROW_W]);
                    end
                    if (i_m_tdata[COL_LSB +: COL_W] !== want.col) begin
                        report_mismatch("cell_column", want.row, want.col, want.col,
                                        i_m_tdata[COL_LSB +: COL_W]);
                    end
                    if (i_m_tlast !== want.ends_run) begin
                        report_mismatch("tlast", want.row, want.col, want.ends_run,
                                        i_m_tlast);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_COLUMNS: cols_reg = i_cfg_data[GRID_COLS_W-1:0];
                    CFG_GRID_ROWS:    rows_reg = i_cfg_data[GRID_ROWS_W-1:0];
                    default: ;
                endcase
                col_now = 0;
                row_now = 0;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_height_grid(i_s_tdata[HEIGHT_W-1:0]);
            end
        end
        o_pending    <= flow_expected.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the D8 flow direction block.
// ----------------------------------------------------------------------------
// A short directed run on a 3x3 grid hits an exact tie between a diagonal and
// an orthogonal slope and the largest positive and negative drops. Random
// phases then change the grid size, out-of-range values included, and mix
// sender gaps, receiver stalls, long output hold-offs and full drains.
module tb;
    import sdn_pkg::*;

    localparam int CYCLE_LIMIT      = 100000;
    localparam int HOLD_LEN         = 300;
    localparam int DRAIN_WAIT       = 20;
    localparam int PROBE_ITEMS      = 27;
    localparam int TIE_OFFSET_DIAG  = 65536;
    localparam int TIE_OFFSET_ORTHO = 46341;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};
    localparam logic [HEIGHT_W-1:0] TIE_CENTRE = 24'h100000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // surface_height[23:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // direction[3:0], height_drop[28:4], cell_row[40:29], cell_column[50:41]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = CFG_GRID_COLUMNS;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int unsigned         pending;
    int unsigned         mismatches;
    int unsigned         cycle_count   = 0;
    int unsigned         idle_pct      = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         hold_requests = 0;
    int unsigned         hold_seen     = 0;
    int unsigned         hold_left     = 0;
    logic [HEIGHT_W-1:0] surface_base  = '0;

    always #5 i_clk = ~i_clk;

    steepest_descent_neighbour_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    sdn_flow_checker u_flow_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [HEIGHT_W-1:0] pick_height();
        logic [HEIGHT_W-1:0] h;
        case ($urandom_range(3))
            0: h = HEIGHT_W'($urandom());
            1: h = surface_base + HEIGHT_W'($urandom_range(3));
            2: h = $urandom_range(1) ? HEIGHT_MAX : '0;
            default: h = surface_base - HEIGHT_W'($urandom_range(2)
                         * ($urandom_range(1) ? TIE_OFFSET_DIAG : TIE_OFFSET_ORTHO));
        endcase
        return h;
    endfunction

    task automatic send_height(input logic [HEIGHT_W-1:0] h);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GRID_COLUMNS;
        i_cfg_data <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GRID_ROWS;
        i_cfg_data <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned cols, input int unsigned rows,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int n, input int hold_at, input int pause_at);
        wait_drained();
        set_grid(cols, rows);
        idle_pct     = send_pct;
        stall_pct    = recv_pct;
        surface_base = HEIGHT_W'($urandom());
        for (int j = 0; j < n; j++) begin
            if (j == hold_at) begin
                hold_requests++;
            end
            if (j == pause_at) begin
                wait_drained();
            end
            send_height(pick_height());
        end
    endtask

    initial begin : stimulus
        logic [HEIGHT_W-1:0] h;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_grid(3, 3);
        // Three 3x3 frames: a diagonal/orthogonal slope tie on a flat plateau,
        // a lone peak, and a lone pit.
        for (int k = 0; k < PROBE_ITEMS; k++) begin
            case (k / 9)
                0: begin
                    if (k % 9 == 0) begin
                        h = TIE_CENTRE - HEIGHT_W'(TIE_OFFSET_DIAG);
                    end else if (k % 9 == 1) begin
                        h = TIE_CENTRE - HEIGHT_W'(TIE_OFFSET_ORTHO);
                    end else begin
                        h = TIE_CENTRE;
                    end
                end
                1: h = (k % 9 == 4) ? HEIGHT_MAX : '0;
                default: h = (k % 9 == 4) ? '0 : HEIGHT_MAX;
            endcase
            send_height(h);
        end
        run_phase(4, 5, 0, 0, 20, 2, 12);
        run_phase(0, 8191, 54, 0, 9, -1, -1);
        run_phase(2047, 2, 0, 54, 9, -1, -1);
        run_phase(5, 6, 27, 27, 30, -1, 12);
        run_phase(1024, 4096, 27, 27, 6, -1, -1);
        run_phase(3, 3, 0, 0, 9, 3, -1);
        wait_drained();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/sdn_pkg.sv
hdl/sdn_line_buf.sv
hdl/sdn_select.sv
hdl/steepest_descent_neighbour_top.sv
test/sdn_flow_checker.sv
test/tb.sv
